@@ hw/rtl/bal_pkg.sv @@
`timescale 1ns / 1ps

package bal_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INS_POS  = 3'd0,
    OP_INS_SORT = 3'd1,
    OP_REM_POS  = 3'd2,
    OP_APPEND   = 3'd3,
    OP_REM_LAST = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef struct packed {
    op_e                        operation;
    logic signed [VALUE_W-1:0]  value;
    logic        [POS_W-1:0]    position;
  } in_item_t;

  typedef struct packed {
    status_e                    status;
    logic signed [VALUE_W-1:0]  removed_value;
    logic        [COUNT_W-1:0]  count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } dp_cmd_t;

endpackage

@@ hw/rtl/bal_ctrl.sv @@
`timescale 1ns / 1ps

module bal_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bal_pkg::dp_cmd_t cmd_o
);
  import bal_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign cmd_o.capture   = in_valid_i && (state_q == S_IDLE);
  // result register must be free, or drained in this very cycle
  assign cmd_o.commit    = (state_q == S_APPLY) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (cmd_o.commit) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/bal_datapath.sv @@
`timescale 1ns / 1ps

module bal_datapath #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bal_pkg::dp_cmd_t   cmd_i,
  input  bal_pkg::in_item_t  in_data_i,
  output bal_pkg::out_item_t out_data_o
);
  import bal_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic signed [VALUE_W-1:0] entries_q [CAPACITY];
  logic signed [VALUE_W-1:0] entries_d [CAPACITY];
  logic        [CNT_W-1:0]   count_q, count_d;

  op_e                       op_q;
  logic signed [VALUE_W-1:0] value_q;
  logic        [POS_W-1:0]   pos_q;
  logic        [CAPACITY-1:0] lt_q, lt_d;

  out_item_t                 out_q;

  logic [CMP_W-1:0]          pos_w, cnt_w;
  logic [CNT_W-1:0]          sort_idx, ins_idx, rem_idx;
  logic                      full, empty, do_ins, do_rem;
  status_e                   status;
  logic signed [VALUE_W-1:0] removed;

  // per-cell compare against the incoming value, taken with the transaction
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt_d[i] = (CNT_W'(i) < count_q) && (entries_q[i] < in_data_i.value);
    end
  end

  // first cell that is not below the value
  always_comb begin
    sort_idx = count_q;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!lt_q[i]) begin
        sort_idx = CNT_W'(i);
      end
    end
  end

  assign pos_w = CMP_W'(pos_q);
  assign cnt_w = CMP_W'(count_q);
  assign full  = (count_q == CNT_W'(CAPACITY));
  assign empty = (count_q == '0);

  always_comb begin
    status  = ST_OK;
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    ins_idx = count_q;
    rem_idx = count_q;
    case (op_q)
      OP_INS_POS: begin
        if (full) begin
          status = ST_FULL;
        end else if (pos_w > cnt_w) begin
          status = ST_BADPOS;
        end else begin
          do_ins  = 1'b1;
          ins_idx = pos_w[CNT_W-1:0];
        end
      end
      OP_INS_SORT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          do_ins  = 1'b1;
          ins_idx = sort_idx;
        end
      end
      OP_REM_POS: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status = ST_BADPOS;
        end else begin
          do_rem  = 1'b1;
          rem_idx = pos_w[CNT_W-1:0];
        end
      end
      OP_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          do_ins  = 1'b1;
          ins_idx = count_q;
        end
      end
      OP_REM_LAST: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          do_rem  = 1'b1;
          rem_idx = count_q - CNT_W'(1);
        end
      end
      default: begin
        status = ST_BADPOS;
      end
    endcase
  end

  assign removed = do_rem ? entries_q[rem_idx[IDX_W-1:0]] : '0;

  // shift cells: each cell looks only at its neighbours
  always_comb begin
    entries_d = entries_q;
    count_d   = count_q;
    if (do_ins) begin
      count_d = count_q + CNT_W'(1);
      for (int i = 0; i < CAPACITY; i++) begin
        if (CNT_W'(i) > ins_idx) begin
          entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
        end else if (CNT_W'(i) == ins_idx) begin
          entries_d[i] = value_q;
        end
      end
    end else if (do_rem) begin
      count_d = count_q - CNT_W'(1);
      for (int i = 0; i < CAPACITY; i++) begin
        if ((CNT_W'(i) >= rem_idx) && (i + 1 < CAPACITY)) begin
          entries_d[i] = entries_q[(i + 1 < CAPACITY) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= in_data_i.operation;
      value_q <= in_data_i.value;
      pos_q   <= in_data_i.position;
      lt_q    <= lt_d;
    end
    if (cmd_i.commit) begin
      entries_q           <= entries_d;
      out_q.status        <= status;
      out_q.removed_value <= removed;
      out_q.count         <= COUNT_W'(count_d);
    end
  end

  assign out_data_o = out_q;

endmodule

@@ hw/rtl/bounded_array_list_top.sv @@
`timescale 1ns / 1ps

// the result is registered when the shift of the cell row commits, in the apply state after the accept
// a new transaction is taken only once the last one commits: the accept cycle compares the value
//   across all cells, then the apply state shifts the cell row and is held there by any output stall
// reset: asynchronous active low, clears the entry count and handshake state;
//   entry storage is not cleared and is only read below the count

module bounded_array_list_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bal_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bal_pkg::out_item_t out_data_o
);
  import bal_pkg::*;

  dp_cmd_t cmd;

  bal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  bal_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

  // one transaction at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction taken while one is in flight");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_FULL)
      |-> out_data_o.count == COUNT_W'(CAPACITY))
    else $error("full status with count below capacity");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_EMPTY)
      |-> (out_data_o.count == '0) && (out_data_o.removed_value == '0))
    else $error("empty status with entries held or a removed value");

  a_removed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |-> out_data_o.removed_value == '0)
    else $error("failed operation reports a removed value");

endmodule
